FILE: rtl/core/ptpm_pkg.sv
`default_nettype none

package ptpm_pkg;

   localparam int THREAD_W = 6;
   localparam int FIELD_W  = 32;

   localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 32'd100;

   typedef enum logic [1:0] {
      CLASS_WAIT_FREE = 2'd0,
      CLASS_LOCK_FREE = 2'd1,
      CLASS_BLOCKING  = 2'd2
   } progress_class_type;

endpackage

`default_nettype wire

FILE: rtl/core/per_thread_progress_monitor.sv
`default_nettype none

// Channel    Handshake                 Payload
// request    start / busy              req_thread_number, req_attempt_succeeded
// response   rsp_valid (strobe)        rsp_* counters, totals, rsp_progress_class
// csr        csr_valid / csr_ready     csr_failure_threshold
//
// One event per cycle while busy is low. The thread entry is read from a memory
// with a registered output on the accept edge and written back on the following
// edge, with forwarding from the previous write-back. A result strobes for one
// cycle, rising on the same edge that writes its entry back. After reset a clearing
// pass writes zero to all THREAD_COUNT entries, one per cycle, with busy high until
// the last entry is written. The response side cannot stall; csr_ready is always high.

module per_thread_progress_monitor #(
   parameter int THREAD_COUNT = 64,
   parameter int COUNTER_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 start,
   output logic                                 busy,
   input  logic [ptpm_pkg::THREAD_W-1:0]        req_thread_number,
   input  logic                                 req_attempt_succeeded,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptpm_pkg::FIELD_W-1:0]         csr_failure_threshold,

   output logic                                 rsp_valid,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_attempt_count,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_success_count,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_failure_run,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_longest_run,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_total_attempt_count,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_total_success_count,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_total_failure_count,
   output logic [ptpm_pkg::FIELD_W-1:0]         rsp_longest_retry_run,
   output ptpm_pkg::progress_class_type         rsp_progress_class
);

   import ptpm_pkg::*;

   localparam int IDX_W  = $clog2(THREAD_COUNT);
   localparam int WIDE_W = (COUNTER_BITS > FIELD_W) ? COUNTER_BITS : FIELD_W;
   localparam int LUT_N  = 2 ** THREAD_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_COUNT - 1);

   typedef logic [COUNTER_BITS-1:0] count_type;

   typedef struct packed {
      count_type attempts;
      count_type successes;
      count_type fail_run;
      count_type longest;
   } entry_type;

   function automatic count_type sat_inc(input count_type v);
      return (&v) ? v : v + COUNTER_BITS'(1);
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input count_type v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[FIELD_W-1:0];
   endfunction

   // thread number wraps modulo the table depth
   logic [IDX_W-1:0] wrap_lut [LUT_N];

   for (genvar g = 0; g < LUT_N; g++) begin : g_wrap
      assign wrap_lut[g] = IDX_W'(g % THREAD_COUNT);
   end

   entry_type entry_mem [THREAD_COUNT];

   logic              clear_ff, clear_in;
   logic [IDX_W-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [FIELD_W-1:0] threshold_ff;

   logic              accept;
   logic [IDX_W-1:0]  rd_idx;
   entry_type         rd_data_ff;

   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_ok_ff;

   logic              wb_valid_ff;
   logic [IDX_W-1:0]  wb_idx_ff;
   entry_type         wb_data_ff;

   count_type         sum_att_ff, sum_att_in;
   count_type         sum_succ_ff, sum_succ_in;
   count_type         sum_fail_ff, sum_fail_in;
   count_type         overall_ff, overall_in;
   logic              any_ff, any_in;

   entry_type         cur;
   entry_type         upd;
   progress_class_type class_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   assign busy      = clear_ff;
   assign csr_ready = 1'b1;
   assign accept    = start & ~clear_ff;
   assign rd_idx    = wrap_lut[req_thread_number];

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + IDX_W'(1);
         if (clear_cnt_ff == LAST_IDX) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      cur = (wb_valid_ff && wb_idx_ff == s1_idx_ff) ? wb_data_ff : rd_data_ff;

      upd.attempts  = sat_inc(cur.attempts);
      upd.successes = s1_ok_ff ? sat_inc(cur.successes) : cur.successes;
      upd.fail_run  = s1_ok_ff ? '0 : sat_inc(cur.fail_run);
      upd.longest   = (!s1_ok_ff && upd.fail_run > cur.longest) ? upd.fail_run : cur.longest;

      sum_att_in  = sum_att_ff;
      sum_succ_in = sum_succ_ff;
      sum_fail_in = sum_fail_ff;
      overall_in  = overall_ff;
      any_in      = any_ff;
      if (s1_valid_ff) begin
         sum_att_in = sat_inc(sum_att_ff);
         if (s1_ok_ff) begin
            sum_succ_in = sat_inc(sum_succ_ff);
            any_in      = 1'b1;
         end else begin
            sum_fail_in = sat_inc(sum_fail_ff);
         end
         if (upd.longest > overall_ff) begin
            overall_in = upd.longest;
         end
      end

      if (WIDE_W'(overall_in) <= WIDE_W'(threshold_ff)) begin
         class_in = CLASS_WAIT_FREE;
      end else if (any_in) begin
         class_in = CLASS_LOCK_FREE;
      end else begin
         class_in = CLASS_BLOCKING;
      end

      mem_we    = clear_ff | s1_valid_ff;
      mem_waddr = clear_ff ? clear_cnt_ff : s1_idx_ff;
      mem_wdata = clear_ff ? '0 : upd;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         threshold_ff <= THRESHOLD_RESET;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid    <= 1'b0;
         sum_att_ff   <= '0;
         sum_succ_ff  <= '0;
         sum_fail_ff  <= '0;
         overall_ff   <= '0;
         any_ff       <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_failure_threshold;
         end
         s1_valid_ff  <= accept;
         wb_valid_ff  <= s1_valid_ff;
         rsp_valid    <= s1_valid_ff;
         sum_att_ff   <= sum_att_in;
         sum_succ_ff  <= sum_succ_in;
         sum_fail_ff  <= sum_fail_in;
         overall_ff   <= overall_in;
         any_ff       <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= rd_idx;
      s1_ok_ff   <= req_attempt_succeeded;
      wb_idx_ff  <= s1_idx_ff;
      wb_data_ff <= upd;
      if (s1_valid_ff) begin
         rsp_thread_attempt_count <= to_field(upd.attempts);
         rsp_thread_success_count <= to_field(upd.successes);
         rsp_thread_failure_run   <= to_field(upd.fail_run);
         rsp_thread_longest_run   <= to_field(upd.longest);
         rsp_total_attempt_count  <= to_field(sum_att_in);
         rsp_total_success_count  <= to_field(sum_succ_in);
         rsp_total_failure_count  <= to_field(sum_fail_in);
         rsp_longest_retry_run    <= to_field(overall_in);
         rsp_progress_class       <= class_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ptpm_checker.sv
`default_nettype none

module ptpm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_failure_run,
   input logic [ptpm_pkg::FIELD_W-1:0]         rsp_thread_longest_run,
   input logic [ptpm_pkg::FIELD_W-1:0]         rsp_total_success_count,
   input logic [ptpm_pkg::FIELD_W-1:0]         rsp_longest_retry_run,
   input ptpm_pkg::progress_class_type         rsp_progress_class
);

   import ptpm_pkg::*;

   // every accepted beat yields exactly one strobe, after the s1 stage and the response register
   a_beat_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted beat produced no response");

   a_rsp_has_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without accepted beat");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_thread_failure_run <= rsp_thread_longest_run) &&
                    (rsp_thread_longest_run <= rsp_longest_retry_run))
      else $error("failure runs out of order");

   a_blocking: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_progress_class == CLASS_BLOCKING) |->
         rsp_total_success_count == '0)
      else $error("blocking class after a success");

endmodule

bind per_thread_progress_monitor ptpm_checker u_ptpm_checker (
   .clock                   (clock),
   .reset                   (reset),
   .start                   (start),
   .busy                    (busy),
   .rsp_valid               (rsp_valid),
   .rsp_thread_failure_run  (rsp_thread_failure_run),
   .rsp_thread_longest_run  (rsp_thread_longest_run),
   .rsp_total_success_count (rsp_total_success_count),
   .rsp_longest_retry_run   (rsp_longest_retry_run),
   .rsp_progress_class      (rsp_progress_class)
);

`default_nettype wire

FILE: tb/tb_per_thread_progress_monitor.sv
`timescale 1ns / 100ps

module tb_per_thread_progress_monitor;

   import ptpm_pkg::*;

   localparam int THREADS     = 64;
   localparam int CYCLE_LIMIT = 100000;
   localparam int REPORT_MAX  = 10;
   localparam int DRAIN_WAIT  = 8;
   localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

   typedef struct {
      logic [FIELD_W-1:0] thread_attempts;
      logic [FIELD_W-1:0] thread_successes;
      logic [FIELD_W-1:0] thread_failure_run;
      logic [FIELD_W-1:0] thread_longest_run;
      logic [FIELD_W-1:0] overall_attempts;
      logic [FIELD_W-1:0] total_successes;
      logic [FIELD_W-1:0] total_failures;
      logic [FIELD_W-1:0] longest_retry;
      progress_class_type progress;
   } progress_report_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [THREAD_W-1:0] req_thread_number;
   logic                req_attempt_succeeded;
   logic                csr_valid;
   logic                csr_ready;
   logic [FIELD_W-1:0]  csr_failure_threshold;
   logic                rsp_valid;
   logic [FIELD_W-1:0]  rsp_thread_attempt_count;
   logic [FIELD_W-1:0]  rsp_thread_success_count;
   logic [FIELD_W-1:0]  rsp_thread_failure_run;
   logic [FIELD_W-1:0]  rsp_thread_longest_run;
   logic [FIELD_W-1:0]  rsp_total_attempt_count;
   logic [FIELD_W-1:0]  rsp_total_success_count;
   logic [FIELD_W-1:0]  rsp_total_failure_count;
   logic [FIELD_W-1:0]  rsp_longest_retry_run;
   progress_class_type  rsp_progress_class;

   per_thread_progress_monitor dut (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_thread_number        (req_thread_number),
      .req_attempt_succeeded    (req_attempt_succeeded),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_failure_threshold    (csr_failure_threshold),
      .rsp_valid                (rsp_valid),
      .rsp_thread_attempt_count (rsp_thread_attempt_count),
      .rsp_thread_success_count (rsp_thread_success_count),
      .rsp_thread_failure_run   (rsp_thread_failure_run),
      .rsp_thread_longest_run   (rsp_thread_longest_run),
      .rsp_total_attempt_count  (rsp_total_attempt_count),
      .rsp_total_success_count  (rsp_total_success_count),
      .rsp_total_failure_count  (rsp_total_failure_count),
      .rsp_longest_retry_run    (rsp_longest_retry_run),
      .rsp_progress_class       (rsp_progress_class)
   );

   // progress model state
   logic [FIELD_W-1:0] attempts_seen  [THREADS];
   logic [FIELD_W-1:0] successes_seen [THREADS];
   logic [FIELD_W-1:0] fail_streak    [THREADS];
   logic [FIELD_W-1:0] worst_streak   [THREADS];
   logic [FIELD_W-1:0] all_attempts;
   logic [FIELD_W-1:0] all_successes;
   logic [FIELD_W-1:0] all_failures;
   logic [FIELD_W-1:0] worst_overall;
   logic               success_ever;
   logic [FIELD_W-1:0] threshold_model;

   progress_report_type pending_reports[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("per_thread_progress_monitor verification failed");
         $finish;
      end
   end

   function automatic logic [FIELD_W-1:0] sat_bump(input logic [FIELD_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + FIELD_W'(1);
   endfunction

   function automatic progress_report_type advance_progress(input logic [THREAD_W-1:0] t,
                                                             input logic ok);
      progress_report_type r;
      attempts_seen[t] = sat_bump(attempts_seen[t]);
      all_attempts     = sat_bump(all_attempts);
      if (ok) begin
         successes_seen[t] = sat_bump(successes_seen[t]);
         fail_streak[t]    = '0;
         all_successes     = sat_bump(all_successes);
         success_ever      = 1'b1;
      end else begin
         fail_streak[t] = sat_bump(fail_streak[t]);
         if (fail_streak[t] > worst_streak[t]) worst_streak[t] = fail_streak[t];
         all_failures = sat_bump(all_failures);
      end
      if (worst_streak[t] > worst_overall) worst_overall = worst_streak[t];
      r.thread_attempts    = attempts_seen[t];
      r.thread_successes   = successes_seen[t];
      r.thread_failure_run = fail_streak[t];
      r.thread_longest_run = worst_streak[t];
      r.overall_attempts   = all_attempts;
      r.total_successes    = all_successes;
      r.total_failures     = all_failures;
      r.longest_retry      = worst_overall;
      if (worst_overall <= threshold_model) r.progress = CLASS_WAIT_FREE;
      else if (success_ever)                r.progress = CLASS_LOCK_FREE;
      else                                  r.progress = CLASS_BLOCKING;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [FIELD_W-1:0] want,
                                         input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("mismatch %s: expected %0d actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : response_check
      progress_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response beat, attempts %0d", rsp_thread_attempt_count);
         end else begin
            want = pending_reports.pop_front();
            compare_field("thread_attempt_count", want.thread_attempts,
                          rsp_thread_attempt_count);
            compare_field("thread_success_count", want.thread_successes,
                          rsp_thread_success_count);
            compare_field("thread_failure_run", want.thread_failure_run,
                          rsp_thread_failure_run);
            compare_field("thread_longest_run", want.thread_longest_run,
                          rsp_thread_longest_run);
            compare_field("total_attempt_count", want.overall_attempts,
                          rsp_total_attempt_count);
            compare_field("total_success_count", want.total_successes,
                          rsp_total_success_count);
            compare_field("total_failure_count", want.total_failures,
                          rsp_total_failure_count);
            compare_field("longest_retry_run", want.longest_retry, rsp_longest_retry_run);
            compare_field("progress_class", FIELD_W'(want.progress),
                          FIELD_W'(rsp_progress_class));
         end
      end
   end

   // leaves start high on return; the caller either sends again or drops it
   task automatic send_event(input logic [THREAD_W-1:0] t, input logic ok, input int gap);
      progress_report_type expected;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_thread_number     <= t;
      req_attempt_succeeded <= ok;
      do @(posedge clock); while (busy !== 1'b0);
      expected = advance_progress(t, ok);
      pending_reports.insert(pending_reports.size(), expected);
   endtask

   task automatic write_threshold(input logic [FIELD_W-1:0] value);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      csr_valid             <= 1'b1;
      csr_failure_threshold <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      threshold_model = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_threshold();
      send_event(6'd0,  1'b0, $urandom_range(0, 8));
      send_event(6'd63, 1'b0, $urandom_range(0, 8));
      send_event(6'd0,  1'b0, $urandom_range(0, 8));
   endtask

   task automatic test_blocking_without_success();
      write_threshold(32'd0);
      send_event(6'd42, 1'b0, $urandom_range(0, 8));
      send_event(6'd21, 1'b0, 0);
      send_event(6'd42, 1'b0, 0);
   endtask

   task automatic test_success_clears_run();
      send_event(6'd0,  1'b1, $urandom_range(0, 8));
      send_event(6'd0,  1'b0, 0);
      send_event(6'd63, 1'b1, $urandom_range(0, 8));
      send_event(6'd63, 1'b1, 0);
   endtask

   task automatic test_threshold_extremes();
      write_threshold(32'hFFFF_FFFF);
      send_event(6'd21, 1'b0, $urandom_range(0, 8));
      send_event(6'd21, 1'b0, 0);
      write_threshold(worst_overall);
      send_event(6'd42, 1'b0, $urandom_range(0, 8));
      send_event(6'd42, 1'b0, 0);
      send_event(6'd42, 1'b0, $urandom_range(0, 8));
   endtask

   // bursts of failures on one thread, mixed with random events, can push the longest run past the threshold
   task automatic test_random_traffic();
      int                  phase;
      int                  sent;
      int                  max_gap;
      int                  burst;
      logic [THREAD_W-1:0] t;
      logic [FIELD_W-1:0]  limit_value;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: limit_value = worst_overall;
            1: limit_value = 32'd0;
            2: limit_value = $urandom_range(0, worst_overall + 10);
            3: limit_value = 32'hFFFF_FFFF;
            4: limit_value = worst_overall + $urandom_range(1, 6);
            default: limit_value = $urandom();
         endcase
         max_gap = (phase % 2 == 1) ? 0 : 8;
         write_threshold(limit_value);
         sent = 0;
         while (sent < 125) begin
            if ($urandom_range(0, 1)) begin
               t     = THREAD_W'($urandom_range(0, THREADS - 1));
               burst = $urandom_range(3, 30);
               repeat (burst) begin
                  send_event(t, 1'b0, $urandom_range(0, max_gap));
                  sent++;
               end
               if ($urandom_range(0, 9) < 7) begin
                  send_event(t, 1'b1, $urandom_range(0, max_gap));
                  sent++;
               end
            end else begin
               burst = $urandom_range(4, 10);
               repeat (burst) begin
                  send_event(THREAD_W'($urandom_range(0, THREADS - 1)),
                             1'($urandom_range(0, 1)),
                             $urandom_range(0, max_gap));
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < THREADS; i++) begin
         attempts_seen[i]  = '0;
         successes_seen[i] = '0;
         fail_streak[i]    = '0;
         worst_streak[i]   = '0;
      end
      all_attempts    = '0;
      all_successes   = '0;
      all_failures    = '0;
      worst_overall   = '0;
      success_ever    = 1'b0;
      threshold_model = THRESHOLD_RESET;

      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_thread_number     <= '0;
      req_attempt_succeeded <= 1'b0;
      csr_valid             <= 1'b0;
      csr_failure_threshold <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_default_threshold();
      test_blocking_without_success();
      test_success_clears_run();
      test_threshold_extremes();
      test_random_traffic();

      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("per_thread_progress_monitor verification clean");
      else
         $display("per_thread_progress_monitor verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/ptpm_pkg.sv
rtl/core/per_thread_progress_monitor.sv
rtl/core/ptpm_checker.sv
tb/tb_per_thread_progress_monitor.sv
